// File: sv/srac_pkg.sv
package srac_pkg;

  localparam int SIDE_W = 5;
  localparam int PCNT_W = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int GRID_N_W = 2 * SIDE_W;
  localparam int BLK_W = 9;
  localparam int SMALL_REGION = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIECE_COUNT = 1'b1;

  localparam logic [SIDE_W-1:0] GRID_SIDE_RST = 5'd4;
  localparam logic [PCNT_W-1:0] PIECE_COUNT_RST = 7'd1;

  typedef struct packed {
    logic cell_free;
    logic last_cell;
  } in_req_t;

  typedef struct packed {
    logic [BLK_W-1:0] blocked_cells;
    logic             keep_going;
  } out_req_t;

  typedef struct packed {
    logic free_we;
    logic free_wdata;
    logic vis_we;
    logic vis_wdata;
  } cmem_ctl_t;

  typedef struct packed {
    logic free;
    logic vis;
  } cmem_rd_t;

endpackage

// File: sv/srac_cell_mem.sv
module srac_cell_mem #(
  parameter int DEPTH = 256,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  srac_pkg::cmem_ctl_t ctl,
  input  logic [AW-1:0]       free_waddr,
  input  logic [AW-1:0]       vis_waddr,
  input  logic [AW-1:0]       raddr,
  output srac_pkg::cmem_rd_t  rd
);

  logic free_mem [DEPTH];
  logic vis_mem [DEPTH];
  logic free_rd_r;
  logic vis_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.free_we) begin
      free_mem[free_waddr] <= ctl.free_wdata;
    end
    free_rd_r <= free_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.vis_we) begin
      vis_mem[vis_waddr] <= ctl.vis_wdata;
    end
    vis_rd_r <= vis_mem[raddr];
  end

  assign rd.free = free_rd_r;
  assign rd.vis  = vis_rd_r;

endmodule

// File: sv/srac_stack.sv
module srac_stack #(
  parameter int DEPTH = 256,
  parameter int EW = 16,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/small_region_area_counter.sv
// Loading: one cell per cycle, a new request accepted every cycle until last_cell.
// Count after last_cell: each cell is scanned with a read state and a check state; each
// free cell then takes a stack pop and four neighbor read/check pairs, a region's first
// cell the four pairs only. Then the result is posted once the output register is free,
// and side*side visited-map entries are cleared. Reset: synchronous; all MAX_SIDE*MAX_SIDE
// visited-map bits clear first, in_stall high; configuration writes taken throughout.
module small_region_area_counter #(
  parameter int MAX_SIDE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  srac_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output srac_pkg::out_req_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srac_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int IW = $clog2(CELLS);
  localparam int XW = $clog2(MAX_SIDE);
  localparam int SW = srac_pkg::SIDE_W;
  localparam int NW = srac_pkg::GRID_N_W;
  localparam int PW = (IW > NW) ? IW : NW;
  localparam int CW = ((XW > SW) ? XW : SW) + 1;
  localparam int DW = $clog2(CELLS + 1);
  localparam int EW = IW + 2 * XW;
  localparam int SPW = NW + 2;
  localparam int BW = srac_pkg::BLK_W;
  localparam int PCW = srac_pkg::PCNT_W;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP_RD,
    ST_POP_USE,
    ST_NB_RD,
    ST_NB_CHK,
    ST_DONE,
    ST_VCLR
  } state_t;

  state_t state_r, state_nxt;
  logic [PW-1:0] lp_r, lp_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [NW-1:0] total_r, total_nxt;
  logic out_valid_r, out_valid_nxt;
  srac_pkg::out_req_t out_data_r, out_data_nxt;
  logic [SW-1:0] grid_side_r, grid_side_nxt;
  logic [PCW-1:0] piece_count_r, piece_count_nxt;

  logic [PW-1:0] si_r, si_nxt;
  logic [XW-1:0] sx_r, sx_nxt;
  logic [XW-1:0] sy_r, sy_nxt;
  logic [PW-1:0] cur_idx_r, cur_idx_nxt;
  logic [XW-1:0] cur_x_r, cur_x_nxt;
  logic [XW-1:0] cur_y_r, cur_y_nxt;
  logic [1:0] k_r, k_nxt;
  logic nb_ok_r, nb_ok_nxt;
  logic [PW-1:0] nb_idx_r, nb_idx_nxt;
  logic [XW-1:0] nb_x_r, nb_x_nxt;
  logic [XW-1:0] nb_y_r, nb_y_nxt;
  logic [NW-1:0] region_r, region_nxt;

  logic [SW-1:0] side_w;
  logic [NW-1:0] n_w;
  logic [PW-1:0] n_p;
  logic [PW-1:0] delta_w;
  logic [PW-1:0] nb_idx_w;
  logic [XW-1:0] nb_x_w;
  logic [XW-1:0] nb_y_w;
  logic nb_ok_w;
  logic signed [SPW-1:0] spare_w;
  logic keep_w;
  logic in_acc;
  logic [PW-1:0] pos_w;
  logic push_w;
  logic scan_last_w;

  srac_pkg::cmem_ctl_t cm_ctl;
  srac_pkg::cmem_rd_t cm_rd;
  logic [IW-1:0] cm_free_waddr;
  logic [IW-1:0] cm_vis_waddr;
  logic [IW-1:0] cm_raddr;

  logic st_we;
  logic [IW-1:0] st_waddr;
  logic [EW-1:0] st_wdata;
  logic [IW-1:0] st_raddr;
  logic [EW-1:0] st_rdata;

  srac_cell_mem #(.DEPTH(CELLS), .AW(IW)) u_cell_mem (
    .clk       (clk),
    .ctl       (cm_ctl),
    .free_waddr(cm_free_waddr),
    .vis_waddr (cm_vis_waddr),
    .raddr     (cm_raddr),
    .rd        (cm_rd)
  );

  srac_stack #(.DEPTH(CELLS), .EW(EW), .AW(IW)) u_stack (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  assign side_w = (int'(grid_side_r) > MAX_SIDE) ? SW'(MAX_SIDE) : grid_side_r;
  assign n_w = NW'(side_w) * NW'(side_w);
  assign n_p = PW'(n_w);

  // shared neighbor address unit: right, down, left, up
  assign delta_w = k_r[0] ? PW'(side_w) : PW'(1);
  assign nb_idx_w = k_r[1] ? (cur_idx_r - delta_w) : (cur_idx_r + delta_w);

  always_comb begin
    nb_x_w = cur_x_r;
    nb_y_w = cur_y_r;
    nb_ok_w = 1'b0;
    case (k_r)
      2'd0: begin
        nb_x_w = cur_x_r + XW'(1);
        nb_ok_w = (CW'(cur_x_r) + CW'(1)) < CW'(side_w);
      end
      2'd1: begin
        nb_y_w = cur_y_r + XW'(1);
        nb_ok_w = (CW'(cur_y_r) + CW'(1)) < CW'(side_w);
      end
      2'd2: begin
        nb_x_w = cur_x_r - XW'(1);
        nb_ok_w = (cur_x_r != '0);
      end
      2'd3: begin
        nb_y_w = cur_y_r - XW'(1);
        nb_ok_w = (cur_y_r != '0);
      end
      default: begin
        nb_ok_w = 1'b0;
      end
    endcase
  end

  assign spare_w = $signed(SPW'(n_w)) - $signed(SPW'({piece_count_r, 2'b00}));
  assign keep_w = !(spare_w < $signed(SPW'(total_r)));

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc = in_valid && !in_stall;
  assign pos_w = (lp_r >= n_p) ? '0 : lp_r;
  assign push_w = (state_r == ST_NB_CHK) && nb_ok_r && cm_rd.free && !cm_rd.vis;
  assign scan_last_w = (si_r + PW'(1)) == n_p;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    state_nxt = state_r;
    lp_nxt = lp_r;
    clr_nxt = clr_r;
    depth_nxt = depth_r;
    total_nxt = total_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    grid_side_nxt = grid_side_r;
    piece_count_nxt = piece_count_r;
    si_nxt = si_r;
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    cur_idx_nxt = cur_idx_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    k_nxt = k_r;
    nb_ok_nxt = nb_ok_r;
    nb_idx_nxt = nb_idx_r;
    nb_x_nxt = nb_x_r;
    nb_y_nxt = nb_y_r;
    region_nxt = region_r;

    cm_ctl = '0;
    cm_free_waddr = pos_w[IW-1:0];
    cm_vis_waddr = clr_r[IW-1:0];
    cm_raddr = si_r[IW-1:0];
    st_we = 1'b0;
    st_waddr = depth_r[IW-1:0];
    st_wdata = {nb_idx_r[IW-1:0], nb_x_r, nb_y_r};
    st_raddr = st_waddr - IW'(1);

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srac_pkg::CFG_GRID_SIDE:   grid_side_nxt = cfg_data[SW-1:0];
        srac_pkg::CFG_PIECE_COUNT: piece_count_nxt = cfg_data[PCW-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        cm_ctl.vis_we = 1'b1;
        if (clr_r == PW'(CELLS - 1)) begin
          clr_nxt = '0;
          state_nxt = ST_LOAD;
        end else begin
          clr_nxt = clr_r + PW'(1);
        end
      end
      ST_LOAD: begin
        if (in_acc) begin
          if (n_w != '0) begin
            cm_ctl.free_we = 1'b1;
            cm_ctl.free_wdata = in_data.cell_free;
            lp_nxt = pos_w + PW'(1);
          end
          if (in_data.last_cell) begin
            lp_nxt = '0;
            total_nxt = '0;
            si_nxt = '0;
            sx_nxt = '0;
            sy_nxt = '0;
            depth_nxt = '0;
            state_nxt = (n_w == '0) ? ST_DONE : ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (cm_rd.free && !cm_rd.vis) begin
          cm_ctl.vis_we = 1'b1;
          cm_ctl.vis_wdata = 1'b1;
          cm_vis_waddr = si_r[IW-1:0];
          cur_idx_nxt = si_r;
          cur_x_nxt = sx_r;
          cur_y_nxt = sy_r;
          region_nxt = NW'(1);
          k_nxt = 2'd0;
          state_nxt = ST_NB_RD;
        end else if (scan_last_w) begin
          state_nxt = ST_DONE;
        end else begin
          si_nxt = si_r + PW'(1);
          if ((CW'(sx_r) + CW'(1)) == CW'(side_w)) begin
            sx_nxt = '0;
            sy_nxt = sy_r + XW'(1);
          end else begin
            sx_nxt = sx_r + XW'(1);
          end
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_NB_RD: begin
        cm_raddr = nb_idx_w[IW-1:0];
        nb_ok_nxt = nb_ok_w;
        nb_idx_nxt = nb_idx_w;
        nb_x_nxt = nb_x_w;
        nb_y_nxt = nb_y_w;
        state_nxt = ST_NB_CHK;
      end
      ST_NB_CHK: begin
        if (push_w) begin
          cm_ctl.vis_we = 1'b1;
          cm_ctl.vis_wdata = 1'b1;
          cm_vis_waddr = nb_idx_r[IW-1:0];
          st_we = 1'b1;
          depth_nxt = depth_r + DW'(1);
        end
        if (k_r != 2'd3) begin
          k_nxt = k_r + 2'd1;
          state_nxt = ST_NB_RD;
        end else if (push_w || depth_r != '0) begin
          state_nxt = ST_POP_RD;
        end else begin
          if (int'(region_r) < srac_pkg::SMALL_REGION) begin
            total_nxt = total_r + region_r;
          end
          if (scan_last_w) begin
            state_nxt = ST_DONE;
          end else begin
            si_nxt = si_r + PW'(1);
            if ((CW'(sx_r) + CW'(1)) == CW'(side_w)) begin
              sx_nxt = '0;
              sy_nxt = sy_r + XW'(1);
            end else begin
              sx_nxt = sx_r + XW'(1);
            end
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_POP_RD: begin
        depth_nxt = depth_r - DW'(1);
        state_nxt = ST_POP_USE;
      end
      ST_POP_USE: begin
        cur_idx_nxt = PW'(st_rdata[EW-1 -: IW]);
        cur_x_nxt = st_rdata[2*XW-1 -: XW];
        cur_y_nxt = st_rdata[XW-1:0];
        region_nxt = region_r + NW'(1);
        k_nxt = 2'd0;
        state_nxt = ST_NB_RD;
      end
      ST_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.blocked_cells = total_r[BW-1:0];
          out_data_nxt.keep_going = keep_w;
          clr_nxt = '0;
          state_nxt = (n_w == '0) ? ST_LOAD : ST_VCLR;
        end
      end
      ST_VCLR: begin
        cm_ctl.vis_we = 1'b1;
        if ((clr_r + PW'(1)) == n_p) begin
          clr_nxt = '0;
          state_nxt = ST_LOAD;
        end else begin
          clr_nxt = clr_r + PW'(1);
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      lp_r <= '0;
      clr_r <= '0;
      depth_r <= '0;
      total_r <= '0;
      out_valid_r <= 1'b0;
      out_data_r <= '0;
      grid_side_r <= srac_pkg::GRID_SIDE_RST;
      piece_count_r <= srac_pkg::PIECE_COUNT_RST;
    end else begin
      state_r <= state_nxt;
      lp_r <= lp_nxt;
      clr_r <= clr_nxt;
      depth_r <= depth_nxt;
      total_r <= total_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r <= out_data_nxt;
      grid_side_r <= grid_side_nxt;
      piece_count_r <= piece_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r <= si_nxt;
    sx_r <= sx_nxt;
    sy_r <= sy_nxt;
    cur_idx_r <= cur_idx_nxt;
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    k_r <= k_nxt;
    nb_ok_r <= nb_ok_nxt;
    nb_idx_r <= nb_idx_nxt;
    nb_x_r <= nb_x_nxt;
    nb_y_r <= nb_y_nxt;
    region_r <= region_nxt;
  end

  // current cell is visited and off the stack, so the stack stays below the grid size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NB_CHK) |-> (int'(depth_r) < int'(n_w)))
    else $error("fill stack deeper than grid");

  a_region_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NB_CHK) |-> (region_r != '0 && int'(region_r) <= int'(n_w)))
    else $error("region size out of range");

  a_clr_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLR) |=> (state_r != ST_CLR))
    else $error("reset clearing pass re-entered");

endmodule
